@@ hdl/leb_pkg.sv @@
// ----------------------------------------------------------------------------
// leb_pkg: shared types and constants for the LEB128 codec
// Widths of the stream ports, operation and kind codes, decoder input and result bundles.
// ----------------------------------------------------------------------------
package leb_pkg;

    // Width of a decoded or encoded value, 8 to 64
    localparam int VALUE_WIDTH = 64;
    localparam int SHIFT_W     = $clog2(VALUE_WIDTH + 7);

    // Port widths: tdata carries byte and value, padded to whole bytes
    localparam int S_DATA_W = ((8 + 64 + 7) / 8) * 8;
    localparam int M_DATA_W = ((64 + 8 + 7) / 8) * 8;
    localparam int S_USER_W = 2;
    localparam int M_USER_W = 2;

    // Operation codes
    localparam logic [1:0] OP_UDEC = 2'd0;
    localparam logic [1:0] OP_SDEC = 2'd1;
    localparam logic [1:0] OP_ENC  = 2'd2;

    // Result kinds
    localparam logic KIND_VALUE = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    // Byte field constants
    localparam logic [6:0] PAYLOAD_ONES = 7'h7f;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    typedef struct packed {
        logic [7:0] data;
        logic       sgn;
    } dec_in_t;

    typedef struct packed {
        value_t value;
        logic   ovf;
    } dec_res_t;

endpackage

@@ hdl/leb_dec.sv @@
// ----------------------------------------------------------------------------
// leb_dec: LEB128 decode state and per-byte update
// Holds accumulator, running shift and overflow flag; gives the finished
// value for a final byte and advances the state when told to step.
// ----------------------------------------------------------------------------
module leb_dec (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  leb_pkg::dec_in_t din,
    output leb_pkg::dec_res_t res
);
    import leb_pkg::*;

    typedef logic [VALUE_WIDTH+6:0] wide_t;

    value_t             acc_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic               lost_reg;

    logic [6:0]         payload;
    logic               final_byte;
    logic               sgn_final;
    logic               in_range;
    wide_t              pay_wide;
    wide_t              ones_wide;
    value_t             acc_or;
    value_t             fill;
    value_t             acc_new;
    logic [6:0]         dropped;
    logic [6:0]         dropped_ones;
    logic [6:0]         expect_bits;
    logic [SHIFT_W:0]   top_pos;
    logic               fill_en;
    logic               lost_new;

    always_comb
    begin
        payload      = din.data[6:0];
        final_byte   = !din.data[7];
        sgn_final    = final_byte && din.sgn;
        in_range     = shift_reg < SHIFT_W'(VALUE_WIDTH);
        pay_wide     = wide_t'(payload) << shift_reg;
        ones_wide    = wide_t'(PAYLOAD_ONES) << shift_reg;
        acc_or       = acc_reg | (in_range ? pay_wide[VALUE_WIDTH-1:0] : '0);
        // bits that land at or above the value width
        dropped      = in_range ? pay_wide[VALUE_WIDTH+6:VALUE_WIDTH] : payload;
        dropped_ones = in_range ? ones_wide[VALUE_WIDTH+6:VALUE_WIDTH] : PAYLOAD_ONES;
        top_pos      = (SHIFT_W+1)'(shift_reg) + (SHIFT_W+1)'(7);
        fill_en      = sgn_final && din.data[6] && (top_pos < (SHIFT_W+1)'(VALUE_WIDTH));
        fill         = {VALUE_WIDTH{1'b1}} << top_pos;
        acc_new      = fill_en ? (acc_or | fill) : acc_or;
        // signed end byte: dropped bits must copy the sign
        expect_bits  = (sgn_final && acc_new[VALUE_WIDTH-1]) ? dropped_ones : 7'd0;
        lost_new     = lost_reg | (dropped != expect_bits);
        res.value    = acc_new;
        res.ovf      = lost_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            shift_reg <= '0;
            lost_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (final_byte)
            begin
                acc_reg   <= '0;
                shift_reg <= '0;
                lost_reg  <= 1'b0;
            end
            else
            begin
                acc_reg  <= acc_new;
                lost_reg <= lost_new;
                if (in_range)
                begin
                    shift_reg <= shift_reg + SHIFT_W'(7);
                end
            end
        end
    end

endmodule

@@ hdl/leb128_codec.sv @@
// ----------------------------------------------------------------------------
// leb128_codec: 64-bit LEB128 varint codec
// Unsigned and signed decode one byte per transfer; encode turns one value
// into its minimal byte run.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)       | tuser (low bit up)  | tlast
//  s_*     | in  | in_byte, in_value        | operation           | -
//  m_*     | out | out_value, out_byte      | kind, overflow      | last
//
//  The input register can take a new decode byte every cycle while the
//  result register drains.
//  An encode item stays in the input register until its last output byte
//  is emitted; its 1 to 10 bytes come from a 7-bit shift of the held value.
//  Reset clears the decode state and both valid flags.
//  A stalled m_tready holds any item that needs to emit a result.
// ----------------------------------------------------------------------------
module leb128_codec (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [leb_pkg::S_DATA_W-1:0]  s_tdata,   // in_byte, in_value
    input  logic [leb_pkg::S_USER_W-1:0]  s_tuser,   // operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [leb_pkg::M_DATA_W-1:0]  m_tdata,   // out_value, out_byte
    output logic [leb_pkg::M_USER_W-1:0]  m_tuser,   // kind, overflow
    output logic                          m_tlast
);
    import leb_pkg::*;

    // input register
    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [7:0]  byte_reg;
    value_t      val_reg;
    value_t      val_next;

    // result register
    logic        out_valid_reg;
    logic        kind_reg;
    logic [63:0] value_reg;
    logic [7:0]  obyte_reg;
    logic        last_reg;
    logic        ovf_reg;

    logic        out_free;
    logic        done;
    logic        emit;
    logic        dec_step;
    logic        enc_more;
    logic [7:0]  enc_byte;
    dec_in_t     dec_in;
    dec_res_t    dec_res;

    assign out_free = !out_valid_reg || m_tready;
    assign enc_more = |val_reg[VALUE_WIDTH-1:7];
    assign enc_byte = {enc_more, val_reg[6:0]};
    assign dec_in   = '{data: byte_reg, sgn: (op_reg == OP_SDEC)};

    always_comb
    begin
        done     = 1'b0;
        emit     = 1'b0;
        dec_step = 1'b0;
        val_next = val_reg;
        if (in_valid_reg)
        begin
            case (op_reg)
                OP_UDEC, OP_SDEC:
                begin
                    if (byte_reg[7])
                    begin
                        dec_step = 1'b1;
                        done     = 1'b1;
                    end
                    else if (out_free)
                    begin
                        dec_step = 1'b1;
                        done     = 1'b1;
                        emit     = 1'b1;
                    end
                end
                OP_ENC:
                begin
                    if (out_free)
                    begin
                        emit     = 1'b1;
                        done     = !enc_more;
                        val_next = val_reg >> 7;
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end
    end

    assign s_tready = !in_valid_reg || done;

    leb_dec u_dec (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (dec_step),
        .din   (dec_in),
        .res   (dec_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload of the input register: load on transfer, shift while encoding
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= s_tuser[1:0];
            byte_reg <= s_tdata[7:0];
            val_reg  <= s_tdata[8 +: VALUE_WIDTH];
        end
        else if (emit)
        begin
            val_reg <= val_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (op_reg == OP_ENC)
            begin
                kind_reg  <= KIND_BYTE;
                value_reg <= '0;
                obyte_reg <= enc_byte;
                last_reg  <= !enc_more;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                kind_reg  <= KIND_VALUE;
                value_reg <= 64'(dec_res.value);
                obyte_reg <= '0;
                last_reg  <= 1'b1;
                ovf_reg   <= dec_res.ovf;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({obyte_reg, value_reg});
    assign m_tuser  = {ovf_reg, kind_reg};
    assign m_tlast  = last_reg;

    // encoded bytes carry a continuation bit exactly when not last
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0] == KIND_BYTE) |-> (m_tlast == !m_tdata[71]))
        else $error("encoded byte continuation bit disagrees with tlast");

    // a decoded value is always a single, final result with no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0] == KIND_VALUE) |-> (m_tlast && m_tdata[71:64] == 8'd0))
        else $error("decoded value result malformed");

    // hold the input while an encode run still has bytes to send
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && op_reg == OP_ENC && enc_more) |-> !s_tready)
        else $error("input taken during an encode run");

    // encoded results carry no overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0] == KIND_BYTE) |-> !m_tuser[1])
        else $error("overflow flagged on an encoded byte");

endmodule
